// File: src/lsb_first_bit_packer_unit_assert.svh
// assertion macros for the lsb-first bit packer
`ifndef LSB_FIRST_BIT_PACKER_UNIT_ASSERT_SVH
`define LSB_FIRST_BIT_PACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define LBP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lbp_pkg.sv
// shared types and constants for the lsb-first bit packer
package lbp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CAP_W       = 16;
    localparam int POS_W       = 16;
    localparam int EXT_W       = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_ALIGN = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    typedef struct packed {
        logic             ovf;
        logic [2:0]       last_idx;
        logic [POS_W-1:0] base_pos;
        logic [63:0]      data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: src/lbp_front.sv
// front end: takes items, keeps residue and count, issues byte commands
module lbp_front
    import lbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             q_full,
    input  logic [1:0]       action,
    input  logic [63:0]      value,
    input  logic [6:0]       bit_count,
    input  logic             cfg_valid,
    input  logic [CAP_W-1:0] cfg_data,
    output logic             cmd_push,
    output cmd_t             cmd
);

    logic [CAP_W-1:0]       capacity_reg;
    logic [6:0]             pending_bits_reg, pending_bits_next;
    logic [2:0]             pending_count_reg, pending_count_next;
    logic [COUNT_WIDTH-1:0] bytes_written_reg, bytes_written_next;
    logic                   overflow_reg, overflow_next;

    logic                   accept;
    logic [6:0]             n_eff;
    logic [63:0]            val_m;
    logic [71:0]            merged;
    logic [71:0]            tail;
    logic [7:0]             total;
    logic [3:0]             whole;
    logic [EXT_W-1:0]       cap_x, lim_x, cap_eff, bw_x, room;
    logic                   put_ovf, align_ovf;

    assign accept = push && !q_full;

    always_comb
    begin
        n_eff   = (bit_count > 7'd64) ? 7'd64 : bit_count;
        val_m   = value & ~({64{1'b1}} << n_eff);
        merged  = {65'b0, pending_bits_reg} | ({8'b0, val_m} << pending_count_reg);
        total   = {5'b0, pending_count_reg} + {1'b0, n_eff};
        whole   = total[6:3];
        tail    = merged >> {whole, 3'b000};
        cap_x   = EXT_W'(capacity_reg);
        lim_x   = EXT_W'({COUNT_WIDTH{1'b1}});
        cap_eff = (cap_x > lim_x) ? lim_x : cap_x;
        bw_x    = EXT_W'(bytes_written_reg);
        room    = (bw_x >= cap_eff) ? '0 : (cap_eff - bw_x);
        put_ovf   = EXT_W'(whole) > room;
        align_ovf = (room == '0);
    end

    always_comb
    begin
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        bytes_written_next = bytes_written_reg;
        overflow_next      = overflow_reg;
        cmd_push           = 1'b0;
        cmd.ovf            = 1'b0;
        cmd.last_idx       = 3'd0;
        cmd.base_pos       = bw_x[POS_W-1:0];
        cmd.data           = merged[63:0];
        if (accept)
        begin
            case (action)
                ACT_START:
                begin
                    pending_bits_next  = '0;
                    pending_count_next = '0;
                    bytes_written_next = '0;
                    overflow_next      = 1'b0;
                end
                ACT_ALIGN:
                begin
                    if (!overflow_reg && pending_count_reg != 3'd0)
                    begin
                        cmd_push           = 1'b1;
                        cmd.data           = {57'b0, pending_bits_reg};
                        pending_bits_next  = '0;
                        pending_count_next = '0;
                        if (align_ovf)
                        begin
                            overflow_next = 1'b1;
                            cmd.ovf       = 1'b1;
                        end
                        else
                        begin
                            bytes_written_next = bytes_written_reg + COUNT_WIDTH'(1);
                        end
                    end
                end
                ACT_PUT:
                begin
                    if (!overflow_reg)
                    begin
                        if (put_ovf)
                        begin
                            cmd_push           = 1'b1;
                            cmd.ovf            = 1'b1;
                            overflow_next      = 1'b1;
                            pending_bits_next  = '0;
                            pending_count_next = '0;
                        end
                        else
                        begin
                            cmd_push           = (whole != 4'd0);
                            cmd.last_idx       = 3'(whole - 4'd1);
                            pending_bits_next  = tail[6:0];
                            pending_count_next = total[2:0];
                            bytes_written_next = bytes_written_reg + COUNT_WIDTH'(whole);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg      <= CAP_RESET;
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            bytes_written_reg <= '0;
            overflow_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            bytes_written_reg <= bytes_written_next;
            overflow_reg      <= overflow_next;
        end
    end

endmodule

// File: src/lbp_cmd_queue.sv
// short command queue between front and back
module lbp_cmd_queue
    import lbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  cmd_t      wr_cmd,
    input  logic      rd_en,
    output cmd_t      rd_cmd,
    output q_status_t status
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr, do_rd;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_cmd       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/lbp_back.sv
// back end: walks each command one byte a cycle into the result register while that register is free or being popped
module lbp_back
    import lbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             head,
    input  q_status_t        q_status,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       byte_data,
    output logic [POS_W-1:0] byte_position,
    output logic             overflow_hit,
    output logic             last
);

    logic             out_valid_reg;
    logic [7:0]       data_reg;
    logic [POS_W-1:0] pos_reg;
    logic             ovf_reg, last_reg;
    logic [2:0]       idx_reg;
    logic             advance, emit, is_last;

    assign advance = !out_valid_reg || pop;
    assign emit    = advance && !q_status.empty;
    assign is_last = head.ovf || (idx_reg == head.last_idx);
    assign q_pop   = emit && is_last;

    assign empty         = !out_valid_reg;
    assign byte_data     = data_reg;
    assign byte_position = pos_reg;
    assign overflow_hit  = ovf_reg;
    assign last          = last_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg <= head.ovf ? 8'd0 : head.data[{idx_reg, 3'b000} +: 8];
            pos_reg  <= head.base_pos + POS_W'(idx_reg);
            ovf_reg  <= head.ovf;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= !q_status.empty;
            end
            if (emit)
            begin
                idx_reg <= is_last ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

endmodule

// File: src/lsb_first_bit_packer_unit.sv
// top level of the lsb-first bit packer
//
// channel   direction  handshake            payload
// input     in         push / full          action, value, bit_count
// result    out        empty / pop          byte_data, byte_position, overflow_hit, last
// config    in         cfg_valid/cfg_ready  cfg_data (capacity_bytes)
//
// an item is taken whenever the command queue has room
// the byte emitter sends one result a cycle while commands wait and no result is held unpopped: a put completing
// k bytes holds it for k results, so a stream of full 64-bit puts is paced by the emitter once the queue fills
// starts, ignored items and puts that complete no byte leave no command
// reset clears residue, count, overflow and the queue at once; capacity returns to 65535
// a stalled result holds the emitter; the front keeps taking items until the queue fills
module lsb_first_bit_packer_unit
    import lbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       action,
    input  logic [63:0]      value,
    input  logic [6:0]       bit_count,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       byte_data,
    output logic [POS_W-1:0] byte_position,
    output logic             overflow_hit,
    output logic             last,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

`include "lsb_first_bit_packer_unit_assert.svh"

    cmd_t      front_cmd, head_cmd;
    logic      cmd_push, q_pop;
    q_status_t q_status;

    assign full      = q_status.full;
    assign cfg_ready = 1'b1;

    lbp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_full    (q_status.full),
        .action    (action),
        .value     (value),
        .bit_count (bit_count),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    lbp_cmd_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (front_cmd),
        .rd_en  (q_pop),
        .rd_cmd (head_cmd),
        .status (q_status)
    );

    lbp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_cmd),
        .q_status      (q_status),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .byte_data     (byte_data),
        .byte_position (byte_position),
        .overflow_hit  (overflow_hit),
        .last          (last)
    );

    `LBP_ASSERT_IMPL(a_ovf_result_single, !empty && overflow_hit, last && byte_data == 8'd0,
        "overflow result must be a single zero byte")
    `LBP_ASSERT_IMPL(a_no_push_when_full, cmd_push, !q_status.full,
        "command written into a full queue")
    `LBP_ASSERT_IMPL(a_no_pop_when_empty, q_pop, !q_status.empty,
        "command taken from an empty queue")
    `LBP_ASSERT_NEXT(a_result_after_cmd, q_status.empty && cmd_push, !q_status.empty,
        "command lost on its way into the queue")

endmodule

// File: tb/lbp_checker.sv
// checker for the lsb-first bit packer: predicts every byte transfer and compares it
module lbp_checker
    import lbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  logic [1:0]       action,
    input  logic [63:0]      value,
    input  logic [6:0]       bit_count,
    input  logic             empty,
    input  logic             pop,
    input  logic [7:0]       byte_data,
    input  logic [POS_W-1:0] byte_position,
    input  logic             overflow_hit,
    input  logic             last,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    output int               fail_count,
    output int               bytes_due
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             ovf;
        logic             last;
    } out_byte_t;

    out_byte_t              byte_q[$];
    out_byte_t              want;
    logic [6:0]             residue;
    logic [2:0]             residue_len;
    logic [COUNT_WIDTH-1:0] written;
    logic                   sticky_ovf;
    logic [CAP_W-1:0]       capacity;
    int                     errors;

    function automatic int unsigned free_bytes();
        int unsigned lim;
        lim = capacity;
        if (lim > COUNT_MAX)
        begin
            lim = COUNT_MAX;
        end
        return (written >= lim) ? 0 : lim - written;
    endfunction

    task automatic add_byte(input logic [7:0] data, input logic [POS_W-1:0] pos,
                            input logic ovf, input logic fin);
        out_byte_t b;
        b.data = data;
        b.pos  = pos;
        b.ovf  = ovf;
        b.last = fin;
        byte_q.push_back(b);
    endtask

    task automatic flag_overflow();
        sticky_ovf  = 1'b1;
        residue     = '0;
        residue_len = '0;
        add_byte(8'h00, POS_W'(written), 1'b1, 1'b1);
    endtask

    task automatic pack_item(input logic [1:0] act, input logic [63:0] val,
                             input logic [6:0] cnt);
        int unsigned n;
        int unsigned pc;
        int unsigned total;
        int unsigned whole;
        int unsigned rem;
        logic [63:0] bits;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] tail;
        if (act == ACT_START)
        begin
            residue     = '0;
            residue_len = '0;
            written     = '0;
            sticky_ovf  = 1'b0;
            return;
        end
        if (sticky_ovf || (act != ACT_PUT && act != ACT_ALIGN))
        begin
            return;
        end
        if (act == ACT_ALIGN)
        begin
            if (residue_len == 0)
            begin
                return;
            end
            if (free_bytes() == 0)
            begin
                flag_overflow();
                return;
            end
            add_byte({1'b0, residue}, POS_W'(written), 1'b0, 1'b1);
            written     = written + 1'b1;
            residue     = '0;
            residue_len = '0;
            return;
        end
        // put: clamp the count and keep only the low bits
        n    = (cnt > 7'd64) ? 64 : cnt;
        bits = val;
        if (n < 64)
        begin
            bits = val & ((64'd1 << n) - 64'd1);
        end
        pc    = residue_len;
        total = pc + n;
        whole = total / 8;
        rem   = total % 8;
        lo    = {57'd0, residue} | (bits << pc);
        hi    = (pc != 0) ? (bits >> (64 - pc)) : 64'd0;
        if (whole > free_bytes())
        begin
            flag_overflow();
            return;
        end
        for (int unsigned i = 0; i < whole; i++)
        begin
            add_byte(lo[8*i +: 8], POS_W'(written + i), 1'b0, (i + 1) == whole);
        end
        tail        = (whole < 8) ? (lo >> (8 * whole)) : hi;
        residue     = tail[6:0] & ((7'd1 << rem) - 7'd1);
        residue_len = rem[2:0];
        written     = written + whole[COUNT_WIDTH-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_q.delete();
            residue     = '0;
            residue_len = '0;
            written     = '0;
            sticky_ovf  = 1'b0;
            capacity    = CAP_RESET;
            errors      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity = cfg_data;
            end
            if (push && !full)
            begin
                pack_item(action, value, bit_count);
            end
            if (pop && !empty)
            begin
                if (byte_q.size() == 0)
                begin
                    $error("unexpected transfer: byte_data %0h byte_position %0d",
                           byte_data, byte_position);
                    errors++;
                end
                else
                begin
                    want = byte_q.pop_front();
                    if (byte_data !== want.data)
                    begin
                        $error("byte_data expected %0h actual %0h", want.data, byte_data);
                        errors++;
                    end
                    if (byte_position !== want.pos)
                    begin
                        $error("byte_position expected %0d actual %0d", want.pos,
                               byte_position);
                        errors++;
                    end
                    if (overflow_hit !== want.ovf)
                    begin
                        $error("overflow_hit expected %0b actual %0b", want.ovf,
                               overflow_hit);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last expected %0b actual %0b", want.last, last);
                        errors++;
                    end
                end
            end
        end
        fail_count <= errors;
        bytes_due  <= byte_q.size();
    end

endmodule

// File: tb/tb_top.sv
// testbench top for the lsb-first bit packer: stimulus, back-pressure and verdict
module tb_top
    import lbp_pkg::*;
();

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         PHASE_ITEMS   = 56;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    logic [1:0]       action;
    logic [63:0]      value;
    logic [6:0]       bit_count;
    logic             empty;
    logic             pop;
    logic [7:0]       byte_data;
    logic [POS_W-1:0] byte_position;
    logic             overflow_hit;
    logic             last;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    int fail_count;
    int bytes_due;
    int idle_cycles = 0;
    bit send_gaps   = 1'b1;
    bit recv_gaps   = 1'b1;
    bit rx_hold     = 1'b0;

    lsb_first_bit_packer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .action(action), .value(value), .bit_count(bit_count),
        .empty(empty), .pop(pop),
        .byte_data(byte_data), .byte_position(byte_position),
        .overflow_hit(overflow_hit), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    lbp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .action(action), .value(value), .bit_count(bit_count),
        .empty(empty), .pop(pop),
        .byte_data(byte_data), .byte_position(byte_position),
        .overflow_hit(overflow_hit), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .bytes_due(bytes_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random gaps, plus one long hold-off on request
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            pop <= !(recv_gaps && $urandom_range(99) < 27);
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [63:0] val,
                             input logic [6:0] cnt);
        while (send_gaps && $urandom_range(99) < 27)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        action    <= act;
        value     <= val;
        bit_count <= cnt;
        do @(posedge clk); while (full);
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (bytes_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cap(input logic [CAP_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned caps[6];
        int unsigned r;
        int unsigned cnt;
        bit          tight;
        logic [1:0]  act;
        logic [63:0] val;

        push      <= 1'b0;
        action    <= ACT_PUT;
        value     <= '0;
        bit_count <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= CAP_RESET;
        rst_n     <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity, residue handling, clamping, align and unused action
        send_item(ACT_PUT, '1, 7'd0);
        send_item(ACT_PUT, 64'h5, 7'd3);
        send_item(ACT_PUT, '1, 7'd64);
        send_item(ACT_PUT, 64'h0123_4567_89AB_CDEF, 7'd64);
        send_item(ACT_PUT, {$urandom, $urandom}, 7'd127);
        send_item(ACT_PUT, 64'h15, 7'd5);
        send_item(ACT_ALIGN, '1, 7'd64);
        send_item(ACT_ALIGN, '0, 7'd0);
        send_item(ACT_UNUSED, '1, 7'd127);
        send_item(ACT_PUT, 64'hFF, 7'd8);
        send_item(ACT_START, '1, 7'd64);
        send_item(ACT_PUT, 64'h1, 7'd1);
        send_item(ACT_ALIGN, '0, 7'd0);

        // sticky overflow on a small capacity
        drain();
        write_cap(16'd3);
        send_item(ACT_START, '0, 7'd0);
        send_item(ACT_PUT, '1, 7'd64);
        send_item(ACT_PUT, 64'hA5, 7'd8);
        send_item(ACT_ALIGN, '0, 7'd0);
        send_item(ACT_START, '0, 7'd0);
        send_item(ACT_PUT, 64'h00C3_5A, 7'd24);
        send_item(ACT_PUT, 64'h9, 7'd4);
        send_item(ACT_ALIGN, '0, 7'd0);

        // zero capacity
        drain();
        write_cap(16'd0);
        send_item(ACT_START, '0, 7'd0);
        send_item(ACT_PUT, 64'h3C, 7'd8);
        send_item(ACT_START, '0, 7'd0);
        send_item(ACT_PUT, 64'h1, 7'd1);
        send_item(ACT_ALIGN, '0, 7'd0);

        // capacity lowered below the bytes already written
        drain();
        write_cap(16'hFFFF);
        send_item(ACT_START, '0, 7'd0);
        send_item(ACT_PUT, {$urandom, $urandom}, 7'd64);
        send_item(ACT_PUT, {$urandom, $urandom}, 7'd64);
        drain();
        write_cap(16'd10);
        send_item(ACT_PUT, 64'h77, 7'd8);

        caps[0] = 16'hFFFF;
        caps[1] = 1;
        caps[2] = $urandom_range(64, 2);
        caps[3] = 0;
        caps[4] = $urandom_range(16'hFFFF, 1);
        caps[5] = 16'hFFFF;

        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_cap(caps[p][CAP_W-1:0]);
            send_gaps = (p != 4);
            recv_gaps = (p != 4);
            tight     = (caps[p] < 64);
            send_item(ACT_START, {$urandom, $urandom}, 7'($urandom));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 0 && k == 8)
                begin
                    rx_hold = 1'b1;
                end
                r = $urandom_range(99);
                if (r < (tight ? 22 : 6))
                begin
                    act = ACT_START;
                end
                else if (r < (tight ? 25 : 9))
                begin
                    act = ACT_UNUSED;
                end
                else if (r < (tight ? 40 : 22))
                begin
                    act = ACT_ALIGN;
                end
                else
                begin
                    act = ACT_PUT;
                end
                r = $urandom_range(99);
                if (r < 15)
                begin
                    cnt = 64;
                end
                else if (r < 25)
                begin
                    cnt = $urandom_range(127, 65);
                end
                else if (r < 40)
                begin
                    cnt = $urandom_range(8);
                end
                else
                begin
                    cnt = $urandom_range(64);
                end
                r   = $urandom_range(9);
                val = (r == 0) ? '1 : (r == 1) ? '0 : {$urandom, $urandom};
                send_item(act, val, cnt[6:0]);
            end
        end

        drain();
        if (fail_count == 0 && bytes_due == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
